// ----- rtl/bdq_pkg.sv -----
// bdq_pkg: shared types and constants of the bounded deque block
// operation and status codes, sequencer states, default sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned OpW         = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned DefCapacity = 64;

  typedef enum logic [OpW-1:0] {
    OP_FRONT_INSERT  = 3'd0,
    OP_FRONT_REMOVE  = 3'd1,
    OP_BACK_INSERT   = 3'd2,
    OP_REMOVE_SECOND = 3'd3,
    OP_CLEAR         = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ2,
    S_WRITE,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/bdq_if.sv -----
// bdq_in_if and bdq_out_if: valid/ready channels of the bounded deque block
// depends on bdq_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bdq_in_if;
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::OpW-1:0]           operation;
  logic signed [bdq_pkg::DataW-1:0]  data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface bdq_out_if #(
  parameter int unsigned CntW = $clog2(bdq_pkg::DefCapacity + 1)
);
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::StatusW-1:0]       status;
  logic signed [bdq_pkg::DataW-1:0]  data_out;
  logic [CntW-1:0]                   count_after;

  modport source (output valid, output status, output data_out, output count_after,
                  input ready);
  modport sink   (input valid, input status, input data_out, input count_after,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/bounded_deque_with_second_delete.sv -----
// bounded_deque_with_second_delete: top level of the bounded deque
// circular single-port store, shared slot adder, sequencer, result register
// depends on bdq_pkg and the channel interfaces in bdq_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of up to CAPACITY signed 32-bit values, one operation per
// input item and one result item per operation (status, removed value, count
// after). The store is a single-port memory and one modular slot adder serves
// every address calculation. Inserts, front remove, clear, remove second of a lone
// element and failed operations step through accept, execute and respond; remove
// second with two or more elements adds a read and a write-back state, as the
// single store port reads the front entry, then the second entry, then writes the
// front value back over the second slot. A new item is accepted once the
// sequencer is back in idle; the result register lets the item after that
// proceed while a result still waits downstream. No clearing pass is needed.
module bounded_deque_with_second_delete #(
  parameter int unsigned CAPACITY = bdq_pkg::DefCapacity,
  localparam int unsigned IdxW    = $clog2(CAPACITY),
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  bdq_in_if.sink          in_i,
  bdq_out_if.source       out_o
);

  localparam int unsigned DataW = bdq_pkg::DataW;

  bdq_pkg::state_e  state_q, state_d;
  bdq_pkg::op_e     op_q;
  logic [DataW-1:0] din_q;
  logic [IdxW-1:0]  front_q, front_d;
  logic [CntW-1:0]  count_q, count_d;
  bdq_pkg::status_e status_q, status_d;
  logic             use_rd_q, use_rd_d;
  logic [DataW-1:0] hold_q;
  logic [DataW-1:0] rd_q;

  logic             out_valid_q;
  bdq_pkg::status_e out_status_q;
  logic [DataW-1:0] out_data_q;
  logic [CntW-1:0]  out_count_q;

  logic [DataW-1:0] mem_q [CAPACITY];
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_addr;
  logic [DataW-1:0] mem_wdata;

  logic             in_acc;
  logic             out_load;
  logic             is_full, is_empty;

  // shared slot adder: front plus offset, modulo capacity
  logic [IdxW-1:0]  unit_b;
  logic [IdxW:0]    unit_sum;
  logic [IdxW-1:0]  unit_slot;

  assign unit_sum  = {1'b0, front_q} + {1'b0, unit_b};
  assign unit_slot = (unit_sum >= (IdxW+1)'(CAPACITY))
                   ? IdxW'(unit_sum - (IdxW+1)'(CAPACITY))
                   : unit_sum[IdxW-1:0];

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = (state_q == bdq_pkg::S_RESP) && (!out_valid_q || out_o.ready);

  assign in_i.ready        = (state_q == bdq_pkg::S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.data_out    = out_data_q;
  assign out_o.count_after = out_count_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        if (in_acc) state_d = bdq_pkg::S_EXEC;
      end
      bdq_pkg::S_EXEC: begin
        if (op_q == bdq_pkg::OP_REMOVE_SECOND && !is_empty
            && count_q != CntW'(1)) begin
          state_d = bdq_pkg::S_READ2;
        end else begin
          state_d = bdq_pkg::S_RESP;
        end
      end
      bdq_pkg::S_READ2: state_d = bdq_pkg::S_WRITE;
      bdq_pkg::S_WRITE: state_d = bdq_pkg::S_RESP;
      bdq_pkg::S_RESP: begin
        if (out_load) state_d = bdq_pkg::S_IDLE;
      end
      default: state_d = bdq_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    status_d  = status_q;
    use_rd_d  = use_rd_q;
    unit_b    = IdxW'(1);
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = front_q;
    mem_wdata = din_q;
    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        status_d = bdq_pkg::STAT_DONE;
        use_rd_d = 1'b0;
      end
      bdq_pkg::S_EXEC: begin
        case (op_q)
          bdq_pkg::OP_FRONT_INSERT: begin
            unit_b = IdxW'(CAPACITY - 1);
            if (is_full) begin
              status_d = bdq_pkg::STAT_FULL;
            end else begin
              mem_we   = 1'b1;
              mem_addr = unit_slot;
              front_d  = unit_slot;
              count_d  = count_q + CntW'(1);
            end
          end
          bdq_pkg::OP_BACK_INSERT: begin
            unit_b = count_q[IdxW-1:0];
            if (is_full) begin
              status_d = bdq_pkg::STAT_FULL;
            end else begin
              mem_we   = 1'b1;
              mem_addr = unit_slot;
              count_d  = count_q + CntW'(1);
            end
          end
          bdq_pkg::OP_FRONT_REMOVE: begin
            if (is_empty) begin
              status_d = bdq_pkg::STAT_EMPTY;
            end else begin
              mem_re   = 1'b1;
              use_rd_d = 1'b1;
              front_d  = unit_slot;
              count_d  = count_q - CntW'(1);
            end
          end
          bdq_pkg::OP_REMOVE_SECOND: begin
            if (is_empty) begin
              status_d = bdq_pkg::STAT_EMPTY;
            end else begin
              mem_re   = 1'b1;
              use_rd_d = 1'b1;
              if (count_q == CntW'(1)) count_d = '0;
            end
          end
          bdq_pkg::OP_CLEAR: begin
            if (is_empty) begin
              status_d = bdq_pkg::STAT_EMPTY;
            end else begin
              count_d = '0;
            end
          end
          default: ;
        endcase
      end
      bdq_pkg::S_READ2: begin
        mem_re   = 1'b1;
        mem_addr = unit_slot;
      end
      bdq_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_addr  = unit_slot;
        mem_wdata = hold_q;
        front_d   = unit_slot;
        count_d   = count_q - CntW'(1);
      end
      bdq_pkg::S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      status_q    <= bdq_pkg::STAT_DONE;
      use_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
      use_rd_q <= use_rd_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= bdq_pkg::op_e'(in_i.operation);
      din_q <= in_i.data_in;
    end
    if (state_q == bdq_pkg::S_READ2) hold_q <= rd_q;
    if (out_load) begin
      out_status_q <= status_q;
      out_data_q   <= use_rd_q ? rd_q : '0;
      out_count_q  <= count_q;
    end
  end

  // element store, single port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rd_q <= mem_q[mem_addr];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, front_q} < (IdxW+1)'(CAPACITY))
    else $error("front index outside store");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == bdq_pkg::S_EXEC || $past(state_q) == bdq_pkg::S_WRITE))
    else $error("count changed outside execute or write-back");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == bdq_pkg::S_EXEC || state_q == bdq_pkg::S_WRITE))
    else $error("store written outside execute or write-back");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == bdq_pkg::S_EXEC))
    else $error("accepted item not executed");
`endif

endmodule

`default_nettype wire
